/* hdl/lbp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lbp_pkg;

  // Default build parameters.
  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_PIXEL_BITS  = 8;

  // Width of the code and of the output pixel field.
  localparam int CODE_BITS = 8;

  // Configuration register widths and reset values.
  localparam int COLS_W        = 11;
  localparam int ROWS_W        = 16;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int COLUMNS_RESET = 640;
  localparam int ROWS_RESET    = 480;
  localparam int MIN_COLUMNS   = 3;
  localparam int MIN_ROWS      = 3;

  // Depth of the result queue in front of the output port.
  localparam int OUT_FIFO_DEPTH = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS = 1'b0,
    CFG_ROWS    = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                 last;
    logic [CODE_BITS-1:0] value;
  } lbp_result_t;

endpackage

`default_nettype wire

/* hdl/lbp_line_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
// A read of the address being written returns the old contents.
module lbp_line_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/lbp_window.sv */
`timescale 1ns / 1ps
`default_nettype none

// 3x3 window and pattern compare. Only the two older columns are stored;
// the newest column comes straight from the line memory and the input.
module lbp_window import lbp_pkg::*; #(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  shift_i,
  input  wire logic                  interior_i,
  input  wire logic [PIXEL_BITS-1:0] top_i,
  input  wire logic [PIXEL_BITS-1:0] mid_i,
  input  wire logic [PIXEL_BITS-1:0] pix_i,
  output logic      [CODE_BITS-1:0]  value_o
);

  // Column a is the oldest, column b the middle one; rows top, mid, bottom.
  logic [PIXEL_BITS-1:0] col_a_q [3];
  logic [PIXEL_BITS-1:0] col_b_q [3];
  logic [PIXEL_BITS-1:0] centre;
  logic [CODE_BITS-1:0]  code;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_a_q[0] <= col_b_q[0];
      col_a_q[1] <= col_b_q[1];
      col_a_q[2] <= col_b_q[2];
      col_b_q[0] <= top_i;
      col_b_q[1] <= mid_i;
      col_b_q[2] <= pix_i;
    end
  end

  // Neighbours in raster order carry weights 1 through 128.
  always_comb begin
    centre  = col_b_q[1];
    code[0] = col_a_q[0] >= centre;
    code[1] = col_b_q[0] >= centre;
    code[2] = top_i      >= centre;
    code[3] = col_a_q[1] >= centre;
    code[4] = mid_i      >= centre;
    code[5] = col_a_q[2] >= centre;
    code[6] = col_b_q[2] >= centre;
    code[7] = pix_i      >= centre;
    value_o = interior_i ? code : centre[CODE_BITS-1:0];
  end

endmodule

`default_nettype wire

/* hdl/lbp_out_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

// Small result queue that decouples the pipeline from output stalls.
module lbp_out_fifo import lbp_pkg::*; (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  push_i,
  input  wire lbp_result_t                           push_data_i,
  input  wire logic                                  pop_i,
  output logic [$clog2(OUT_FIFO_DEPTH+1)-1:0]        count_o,
  output logic                                       valid_o,
  output lbp_result_t                                data_o
);

  localparam int PTR_W = $clog2(OUT_FIFO_DEPTH);
  localparam int CNT_W = $clog2(OUT_FIFO_DEPTH + 1);

  lbp_result_t       slot_q [OUT_FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(OUT_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(OUT_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign count_o = count_q;
  assign valid_o = count_q != '0;
  assign data_o  = slot_q[rd_ptr_q];

endmodule

`default_nettype wire

/* hdl/lbp_3x3_stream.sv */
// Throughput: one item per cycle, set by the line memory doing one read and one write
// per cycle and by the three-entry result queue, which holds input while it fills up.
// Reset: position, pipeline and queue are cleared; columns go to 640 (clamped to
// MAX_COLUMNS) and rows to 480. The line memory is not swept: an entry is always
// written within the current image before its contents can reach a result item.
`timescale 1ns / 1ps
`default_nettype none

module lbp_3x3_stream import lbp_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int PIXEL_BITS  = DEF_PIXEL_BITS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration write port.
  input  wire logic                               cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]               cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]              cfg_data_i,
  // Input stream.
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // tdata: pixel_in (PIXEL_BITS bits), zero padded to whole bytes.
  input  wire logic [((PIXEL_BITS+7)/8)*8-1:0]    s_axis_tdata_i,
  // tuser: command (1 bit).
  input  wire logic                               s_axis_tuser_i,
  // Output stream.
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // tdata: pixel_out (8 bits).
  output logic [CODE_BITS-1:0]                    m_axis_tdata_o,
  output logic                                    m_axis_tlast_o
);

  localparam int AW     = $clog2(MAX_COLUMNS);
  localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
  localparam int CMP_W  = (CNT_W > COLS_W) ? CNT_W : COLS_W;
  localparam int RW     = ROWS_W + 1;
  localparam int FC_W   = $clog2(OUT_FIFO_DEPTH + 1);
  localparam int RESET_LAST_COL =
    (COLUMNS_RESET > MAX_COLUMNS) ? MAX_COLUMNS - 1 : COLUMNS_RESET - 1;

  // Effective image geometry. The last column index is kept rather than the
  // count, since the row wrap compares against it.
  logic [AW-1:0]     last_col_q, last_col_d;
  logic [ROWS_W-1:0] rows_q, rows_d;
  logic [CMP_W-1:0]  cols_raw;
  logic [ROWS_W-1:0] rows_raw;

  // Position of the next item. The row may run two past the image while
  // the final items are drained out.
  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  // Stage one holds the item whose line memory read is in flight.
  logic                  s1_valid_q;
  logic                  s1_emit_q;
  logic                  s1_last_q;
  logic                  s1_interior_q;
  logic [PIXEL_BITS-1:0] s1_pix_q;
  logic [AW-1:0]         s1_addr_q;
  logic                  s1_fwd_q;
  logic [2*PIXEL_BITS-1:0] fwd_data_q;

  logic                    accept, take, is_drain, row_past, col_zero;
  logic                    emit, interior, last;
  logic [PIXEL_BITS-1:0]   pix_in, pix_eff;
  logic [2*PIXEL_BITS-1:0] mem_rdata, mem_wdata, line_word;
  logic [PIXEL_BITS-1:0]   top_px, mid_px;
  logic [CODE_BITS-1:0]    value;
  logic [FC_W-1:0]         fifo_count;
  logic [FC_W:0]           fifo_claim;
  logic                    push, pop;
  lbp_result_t             push_data, head;

  // ---------------------------------------------------------------------------
  // Configuration. Each write clamps the value into its legal range at once
  // and restarts the image position.
  // ---------------------------------------------------------------------------
  always_comb begin
    cols_raw   = CMP_W'(cfg_data_i[COLS_W-1:0]);
    rows_raw   = cfg_data_i[ROWS_W-1:0];
    last_col_d = last_col_q;
    rows_d     = rows_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COLUMNS: begin
          if (cols_raw < CMP_W'(MIN_COLUMNS)) begin
            last_col_d = AW'(MIN_COLUMNS - 1);
          end else if (cols_raw > CMP_W'(MAX_COLUMNS)) begin
            last_col_d = AW'(MAX_COLUMNS - 1);
          end else begin
            last_col_d = AW'(cols_raw - CMP_W'(1));
          end
        end
        CFG_ROWS: begin
          rows_d = (rows_raw < ROWS_W'(MIN_ROWS)) ? ROWS_W'(MIN_ROWS) : rows_raw;
        end
        default: begin
          last_col_d = last_col_q;
          rows_d     = rows_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= AW'(RESET_LAST_COL);
      rows_q     <= ROWS_W'(ROWS_RESET);
    end else begin
      last_col_q <= last_col_d;
      rows_q     <= rows_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. The queue must have room for every result that could still
  // be pushed, counting the item now in stage one.
  // ---------------------------------------------------------------------------
  assign fifo_claim      = {1'b0, fifo_count} + (FC_W + 1)'(s1_valid_q && s1_emit_q);
  assign s_axis_tready_o = fifo_claim < (FC_W + 1)'(OUT_FIFO_DEPTH);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign pix_in   = s_axis_tdata_i[PIXEL_BITS-1:0];
  assign is_drain = s_axis_tuser_i == CMD_DRAIN;
  assign row_past = row_q >= {1'b0, rows_q};
  assign col_zero = col_q == '0;

  // A drain tick before all pixels of the image have arrived does nothing.
  // Once the image is complete, pixels count as drain ticks and feed zeros.
  assign take    = accept && !(is_drain && !row_past);
  assign pix_eff = row_past ? '0 : pix_in;

  // The window centre trails the input by one row and one column. At the
  // first column the window still shows the end of the previous row, which
  // is always a border pixel. The final result of the image is the one taken
  // at the first column two rows past the last row.
  assign emit     = col_zero ? (row_q >= RW'(2)) : (row_q >= RW'(1));
  assign interior = (col_q >= AW'(2)) && (row_q >= RW'(2)) && !row_past;
  assign last     = col_zero && (row_q == ({1'b0, rows_q} + RW'(1)));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (take) begin
      if (last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_q == last_col_q) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
      s1_last_q  <= 1'b0;
      s1_fwd_q   <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= take;
      if (take) begin
        s1_emit_q <= emit;
        s1_last_q <= last;
        // The item ahead writes its column in the cycle this one reads; when
        // both hit the same column (the first column of a new image right
        // after the final drain tick) its write data is forwarded.
        s1_fwd_q  <= s1_valid_q && (s1_addr_q == col_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_interior_q <= interior;
      s1_pix_q      <= pix_eff;
      s1_addr_q     <= col_q;
      fwd_data_q    <= mem_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Line memory. Each word holds one column of the two previous rows: the
  // older row in the low half, the newer row in the high half. Every item
  // reads its column and writes it back one row further on.
  // ---------------------------------------------------------------------------
  lbp_line_mem #(
    .DEPTH (MAX_COLUMNS),
    .WIDTH (2 * PIXEL_BITS)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (mem_wdata),
    .re_i    (take),
    .raddr_i (col_q),
    .rdata_o (mem_rdata)
  );

  assign line_word = s1_fwd_q ? fwd_data_q : mem_rdata;
  assign top_px    = line_word[PIXEL_BITS-1:0];
  assign mid_px    = line_word[2*PIXEL_BITS-1:PIXEL_BITS];
  assign mem_wdata = {s1_pix_q, mid_px};

  // ---------------------------------------------------------------------------
  // Window and pattern, then the result queue.
  // ---------------------------------------------------------------------------
  lbp_window #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk_i      (clk_i),
    .shift_i    (s1_valid_q),
    .interior_i (s1_interior_q),
    .top_i      (top_px),
    .mid_i      (mid_px),
    .pix_i      (s1_pix_q),
    .value_o    (value)
  );

  assign push            = s1_valid_q && s1_emit_q;
  assign push_data.last  = s1_last_q;
  assign push_data.value = value;
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;

  lbp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .count_o     (fifo_count),
    .valid_o     (m_axis_tvalid_o),
    .data_o      (head)
  );

  assign m_axis_tdata_o = head.value;
  assign m_axis_tlast_o = head.last;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // The input throttle must keep the result queue from overflowing.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && (fifo_count == FC_W'(OUT_FIFO_DEPTH)) && !pop))
    else $error("result pushed into a full queue");

  // Stage one always consumes read data issued in the cycle before.
  a_read_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> s1_valid_q && (s1_addr_q == $past(col_q)))
    else $error("stage one does not match the issued read");

  // When the final result of an image is formed, the position has restarted.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_last_q) |-> (col_q == '0) && (row_q == '0))
    else $error("position not restarted after the final result");

endmodule

`default_nettype wire
